### rtl/core/qmnu_pkg.sv
// Shared types and constants for the QUBO Metropolis node update block.
package qmnu_pkg;

    localparam int OP_W = 3;
    localparam int ROW_W = 6;
    localparam int DELTA_W = 32;
    localparam int ENERGY_W = 48;
    localparam int CFG_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_COUPLING = 3'd0,
        OP_LOAD_NODE     = 3'd1,
        OP_LOAD_ENERGY   = 3'd2,
        OP_VISIT         = 3'd3,
        OP_READ          = 3'd4
    } t_opcode;

    // controller -> datapath commands
    typedef struct packed {
        logic capture;   // latch the input beat
        logic exec;      // do load / read / fetch own flip energy
        logic decide;    // compute threshold product
        logic judge;     // accept/reject, start walk
        logic walk;      // one node of the update walk
        logic finish;    // write own flip energy, build result
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic is_visit;
        logic take;
        logic walk_done;
    } t_sts;

    // exp(-f/256) in Q1.16 via the same rounded Q0.32 recurrence, evaluated
    // at elaboration; used only through the constant tables in qmnu_dp.
    function automatic logic [16:0] exp_frac_calc(input int f);
        logic [63:0] p;
        p = 64'h1_0000_0000;
        for (int m = 0; m < f; m++) begin
            p = (p * 64'd4278222805 + 64'h8000_0000) >> 32;
        end
        return 17'((p + 64'd32768) >> 16);
    endfunction

    function automatic logic [16:0] exp_int_calc(input int k);
        logic [63:0] p;
        p = 64'h1_0000_0000;
        for (int m = 0; m < k; m++) begin
            p = (p * 64'd1580030169 + 64'h8000_0000) >> 32;
        end
        return 17'((p + 64'd32768) >> 16);
    endfunction

endpackage

### rtl/core/qmnu_ctrl.sv
// Controller state machine for the QUBO Metropolis node update block.
module qmnu_ctrl
    import qmnu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_fire,
    input  logic i_out_fire,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EXEC   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_JUDGE  = 7'b0001000,
        S_WALK   = 7'b0010000,
        S_FINISH = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.capture = i_in_fire;
                if (i_in_fire) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = i_sts.is_visit ? S_JUDGE : S_FINISH;
            end
            S_JUDGE: begin
                o_cmd.judge = 1'b1;
                n_state = i_sts.take ? S_WALK : S_FINISH;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_fire) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### rtl/core/qmnu_dp.sv
// Datapath: coupling memory, node state, threshold and flip energy update.
module qmnu_dp
    import qmnu_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int COUPLING_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic [CFG_W-1:0]           i_node_count,
    input  logic [OP_W-1:0]            i_opcode,
    input  logic [ROW_W-1:0]           i_row,
    input  logic [ROW_W-1:0]           i_col,
    input  logic signed [15:0]         i_coupling,
    input  logic                       i_spin_in,
    input  logic signed [DELTA_W-1:0]  i_delta_in,
    input  logic signed [ENERGY_W-1:0] i_energy_in,
    input  logic [15:0]                i_beta,
    input  logic [15:0]                i_random_value,
    output t_sts                       o_sts,
    output logic                       o_accepted,
    output logic                       o_spin_out,
    output logic signed [DELTA_W-1:0]  o_delta_out,
    output logic signed [ENERGY_W-1:0] o_energy_out
);

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int MEM_D = MAX_NODES * MAX_NODES;
    localparam int MEM_AW = $clog2(MEM_D);
    localparam logic signed [DELTA_W+1:0] D_HI = (DELTA_W+2)'(2**(DELTA_W-1) - 1);
    localparam logic signed [DELTA_W+1:0] D_LO = -D_HI - (DELTA_W+2)'(1);

    // constant exponential tables
    logic [16:0] c_frac [256];
    logic [16:0] c_int  [12];
    for (genvar g = 0; g < 256; g++) begin : g_frac
        assign c_frac[g] = exp_frac_calc(g);
    end
    for (genvar g = 0; g < 12; g++) begin : g_int
        assign c_int[g] = exp_int_calc(g);
    end

    // stores
    logic signed [COUPLING_BITS-1:0] r_cmem [MEM_D];
    logic signed [DELTA_W-1:0]       r_fmem [MAX_NODES];
    logic [MAX_NODES-1:0]            r_spin;
    logic signed [ENERGY_W-1:0]      r_energy;

    // latched beat
    logic [OP_W-1:0]           r_op;
    logic [ROW_W-1:0]          r_row, r_col;
    logic signed [15:0]        r_coup;
    logic                      r_spin_in;
    logic signed [DELTA_W-1:0] r_delta_in;
    logic signed [ENERGY_W-1:0] r_energy_in;
    logic [15:0]               r_beta, r_rand;

    logic [CNT_W-1:0]          r_n;
    logic signed [DELTA_W-1:0] r_d;
    logic [47:0]               r_x;
    logic [31:0]               r_prod;
    logic                      r_acc, r_visit_ok;
    logic [CNT_W-1:0]          r_j;
    logic [IDX_W-1:0]          r_ja;   // address of coupling read in flight
    logic                      r_jv;
    logic signed [COUPLING_BITS-1:0] r_cq;
    logic signed [DELTA_W-1:0] r_fq;

    logic [CNT_W-1:0] w_n;
    logic             w_row_ok;
    logic [IDX_W-1:0] w_row;
    logic [IDX_W-1:0] w_jidx;
    logic [MEM_AW-1:0] w_cwa, w_cra;
    logic             w_take;

    assign w_n = (CNT_W'(i_node_count) > CNT_W'(MAX_NODES) ||
                  CNT_W' (i_node_count) != {1'b0, i_node_count} ) ?
                 CNT_W'(MAX_NODES) : CNT_W'(i_node_count);
    assign w_row_ok = {{(32-ROW_W){1'b0}}, r_row} < 32'(MAX_NODES);
    assign w_row = IDX_W'(r_row);
    assign w_jidx = r_j[IDX_W-1:0];
    assign w_cwa = MEM_AW'(MAX_NODES * int'(w_row) + int'(r_col));
    assign w_cra = MEM_AW'(MAX_NODES * int'(w_row) + int'(w_jidx));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_opcode;
            r_row <= i_row;
            r_col <= i_col;
            r_coup <= i_coupling;
            r_spin_in <= i_spin_in;
            r_delta_in <= i_delta_in;
            r_energy_in <= i_energy_in;
            r_beta <= i_beta;
            r_rand <= i_random_value;
            r_n <= w_n;
        end
    end

    // coupling memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_op == OP_LOAD_COUPLING && w_row_ok &&
            {{(32-ROW_W){1'b0}}, r_col} < 32'(MAX_NODES)) begin
            r_cmem[w_cwa] <= COUPLING_BITS'(r_coup);
        end
        r_cq <= r_cmem[w_cra];
    end

    // flip energy memory: read port registered
    logic w_fwr;
    logic [IDX_W-1:0] w_fwa;
    logic signed [DELTA_W-1:0] w_fwd;
    logic [IDX_W-1:0] w_fra;
    always_ff @(posedge i_clk) begin
        if (w_fwr) r_fmem[w_fwa] <= w_fwd;
        r_fq <= r_fmem[w_fra];
    end

    // saturated neighbor update
    logic signed [DELTA_W+1:0] w_sum, w_term;
    logic signed [DELTA_W-1:0] w_sat, w_neg;
    logic                      w_news;
    always_comb begin
        w_news = r_spin[w_row];
        w_term = (DELTA_W+2)'(r_cq) <<< 1;
        if (w_news == r_spin[r_ja]) w_term = -w_term;
        w_sum = (DELTA_W+2)'(r_fq) + w_term;
        if (w_sum > D_HI) w_sat = DELTA_W'(D_HI);
        else if (w_sum < D_LO) w_sat = DELTA_W'(D_LO);
        else w_sat = DELTA_W'(w_sum);
        w_neg = (r_d == DELTA_W'(D_LO)) ? DELTA_W'(D_HI) : -r_d;
    end

    always_comb begin
        w_fwr = 1'b0;
        w_fwa = w_row;
        w_fwd = r_delta_in;
        w_fra = i_cmd.walk ? w_jidx : w_row;
        if (i_cmd.exec && r_op == OP_LOAD_NODE && w_row_ok) w_fwr = 1'b1;
        if (i_cmd.walk && r_jv && r_ja != w_row) begin
            w_fwr = 1'b1;
            w_fwa = r_ja;
            w_fwd = w_sat;
        end
        if (i_cmd.finish && r_acc) begin
            w_fwr = 1'b1;
            w_fwd = w_neg;
        end
    end

    logic signed [ENERGY_W:0] w_esum;
    logic signed [ENERGY_W-1:0] w_esat;
    always_comb begin
        w_esum = (ENERGY_W+1)'(r_energy) + (ENERGY_W+1)'(r_d);
        if (w_esum[ENERGY_W] != w_esum[ENERGY_W-1])
            w_esat = w_esum[ENERGY_W] ? {1'b1, {(ENERGY_W-1){1'b0}}}
                                      : {1'b0, {(ENERGY_W-1){1'b1}}};
        else
            w_esat = w_esum[ENERGY_W-1:0];
    end

    logic [47:0] w_x;
    assign w_x = 48'($unsigned(r_fq)) * 48'(r_beta);

    assign w_take = (r_d <= 0) ||
                    (r_x[47:8] < 40'd12 && {16'd0, r_rand} < r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spin <= '0;
            r_energy <= '0;
            r_acc <= 1'b0;
            r_jv <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_acc <= 1'b0;
                r_visit_ok <= r_op == OP_VISIT &&
                              CNT_W'(r_row) < r_n && w_row_ok;
                if (r_op == OP_LOAD_NODE && w_row_ok) r_spin[w_row] <= r_spin_in;
                if (r_op == OP_LOAD_ENERGY) r_energy <= r_energy_in;
            end
            if (i_cmd.decide) begin
                r_d <= r_fq;
                r_x <= w_x;
            end
            if (i_cmd.judge) begin
                r_j <= '0;
                r_jv <= 1'b0;
                if (w_take) begin
                    r_acc <= 1'b1;
                    r_spin[w_row] <= ~r_spin[w_row];
                    r_energy <= w_esat;
                end
            end
            if (i_cmd.walk) begin
                r_ja <= w_jidx;
                r_jv <= r_j < r_n;
                if (r_j < r_n) r_j <= r_j + CNT_W'(1);
            end
        end
    end

    // threshold product, registered between decide and judge
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide || i_cmd.exec) begin
            r_prod <= 32'((33'(c_int[w_x[11:8] < 4'd12 ? w_x[11:8] : 4'd0]) *
                          33'(c_frac[w_x[7:0]])) >> 16);
        end
    end

    assign o_sts.is_visit  = r_visit_ok;
    assign o_sts.take      = w_take;
    assign o_sts.walk_done = r_jv == 1'b0 && r_j >= r_n;

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_accepted <= r_acc;
            o_spin_out <= w_row_ok ? r_spin[w_row] : 1'b0;
            o_delta_out <= !w_row_ok ? '0 : (r_acc ? w_neg : r_fq);
            o_energy_out <= r_energy;
        end
    end

endmodule

### rtl/core/qubo_metropolis_node_update.sv
// Top level of the QUBO Metropolis node update block.
//  channel | dir | beat contents
//  s_axis  | in  | opcode,row,col,coupling,spin_in,delta_in,energy_in,beta,random_value
//  m_axis  | out | accepted,spin_out,delta_out,energy_out
//  cfg     | in  | node_count
// A beat passes the EXEC, DECIDE, FINISH and OUT states; a visit to an active row also
// passes JUDGE, and an accepted flip adds the walk over the active nodes of one coupling row
// through the single memory read port.
// Reset (synchronous, low) clears spins, energy and node_count to 64.
// The input stays not ready until the result beat is taken.
module qubo_metropolis_node_update
    import qmnu_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int COUPLING_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [6:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[2:0] row[8:3] col[14:9] coupling[30:15] spin_in[31]
    // delta_in[63:32] energy_in[111:64] beta[127:112] random_value[143:128]
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // accepted[0] spin_out[1] delta_out[33:2] energy_out[81:34], zero fill
    output logic [87:0]  m_axis_tdata
);

    logic [CFG_W-1:0] r_node_count;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_acc, w_spin;
    logic signed [DELTA_W-1:0] w_delta;
    logic signed [ENERGY_W-1:0] w_energy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CFG_W'(64);
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_wdata;
        end
    end

    qmnu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (s_axis_tvalid & s_axis_tready),
        .i_out_fire  (m_axis_tvalid & m_axis_tready),
        .i_sts       (w_sts),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    qmnu_dp #(
        .MAX_NODES     (MAX_NODES),
        .COUPLING_BITS (COUPLING_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_node_count   (r_node_count),
        .i_opcode       (s_axis_tdata[2:0]),
        .i_row          (s_axis_tdata[8:3]),
        .i_col          (s_axis_tdata[14:9]),
        .i_coupling     (s_axis_tdata[30:15]),
        .i_spin_in      (s_axis_tdata[31]),
        .i_delta_in     (s_axis_tdata[63:32]),
        .i_energy_in    (s_axis_tdata[111:64]),
        .i_beta         (s_axis_tdata[127:112]),
        .i_random_value (s_axis_tdata[143:128]),
        .o_sts          (w_sts),
        .o_accepted     (w_acc),
        .o_spin_out     (w_spin),
        .o_delta_out    (w_delta),
        .o_energy_out   (w_energy)
    );

    assign m_axis_tdata = {6'd0, w_energy, w_delta, w_spin, w_acc};

endmodule

### tb/qubo_metropolis_node_update_tb.sv
// Self-checking testbench for qubo_metropolis_node_update: random op streams against a model.
module qubo_metropolis_node_update_tb
    import qmnu_pkg::*;
();

    typedef struct packed {
        logic [15:0] rnd;
        logic [15:0] beta;
        logic [47:0] energy;
        logic [31:0] delta;
        logic        spin;
        logic [15:0] coup;
        logic [5:0]  col;
        logic [5:0]  row;
        t_opcode     op;
    } t_beat_in;

    typedef struct packed {
        logic        acc;
        logic        spin;
        logic [31:0] delta;
        logic [47:0] energy;
    } t_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [6:0]   i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [87:0]  m_axis_tdata;

    qubo_metropolis_node_update dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // model state
    logic signed [15:0] mdl_coup [64][64];
    logic               mdl_spin [64];
    logic signed [31:0] mdl_delta [64];
    logic signed [47:0] mdl_energy;
    int                 mdl_nodes;
    logic [16:0]        exp_int_tab [12];
    logic [16:0]        exp_frac_tab [256];
    bit                 delta_set [64];
    bit                 coup_set [64][64];

    t_beat_in pending_beats [$];
    t_result  expected_results [$];
    int       mismatches;
    bit       quiet;
    int       drv_gap, rcv_gap;

    function automatic logic signed [31:0] sat32(input longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input longint v);
        if (v > 64'sd140737488355327) return 48'h7fff_ffff_ffff;
        if (v < -64'sd140737488355328) return 48'h8000_0000_0000;
        return v[47:0];
    endfunction

    function automatic void build_tables();
        logic [63:0] p;
        p = 64'h1_0000_0000;
        for (int m = 0; m < 12; m++) begin
            exp_int_tab[m] = 17'((p + 64'd32768) >> 16);
            p = (p * 64'd1580030169 + 64'h8000_0000) >> 32;
        end
        p = 64'h1_0000_0000;
        for (int m = 0; m < 256; m++) begin
            exp_frac_tab[m] = 17'((p + 64'd32768) >> 16);
            p = (p * 64'd4278222805 + 64'h8000_0000) >> 32;
        end
    endfunction

    function automatic logic [31:0] accept_threshold(input logic signed [31:0] d,
                                                     input logic [15:0] beta);
        logic [63:0] x;
        logic [63:0] k;
        x = 64'(d) * 64'(beta);
        k = x >> 8;
        if (k >= 12) return 0;
        return 32'((64'(exp_int_tab[k]) * 64'(exp_frac_tab[x[7:0]])) >> 16);
    endfunction

    function automatic t_result predict_step(input t_beat_in b);
        t_result r;
        logic signed [31:0] d;
        longint t;
        r.acc = 0;
        case (b.op)
            OP_LOAD_COUPLING: begin
                mdl_coup[b.row][b.col] = b.coup;
            end
            OP_LOAD_NODE: begin
                mdl_spin[b.row] = b.spin;
                mdl_delta[b.row] = b.delta;
            end
            OP_LOAD_ENERGY: mdl_energy = b.energy;
            OP_VISIT: begin
                if (b.row < mdl_nodes) begin
                    d = mdl_delta[b.row];
                    if (d <= 0 || 32'(b.rnd) < accept_threshold(d, b.beta)) begin
                        r.acc = 1;
                        mdl_spin[b.row] = ~mdl_spin[b.row];
                        mdl_energy = sat48(longint'(mdl_energy) + longint'(d));
                        for (int j = 0; j < mdl_nodes; j++) begin
                            if (j != b.row) begin
                                t = (mdl_spin[j] ? -2 : 2) * longint'(mdl_coup[b.row][j]);
                                if (!mdl_spin[b.row]) t = -t;
                                mdl_delta[j] = sat32(longint'(mdl_delta[j]) + t);
                            end
                        end
                        mdl_delta[b.row] = sat32(-longint'(d));
                    end
                end
            end
            default: ;
        endcase
        r.spin = mdl_spin[b.row];
        r.delta = mdl_delta[b.row];
        r.energy = mdl_energy;
        return r;
    endfunction

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
            drv_gap <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (drv_gap > 0) begin
                s_axis_tvalid <= 0;
                drv_gap <= drv_gap - 1;
            end else if (pending_beats.size() > 0) begin
                s_axis_tvalid <= 1;
                s_axis_tdata <= pending_beats.pop_front();
                if (!quiet && $urandom_range(0, 5) == 0) drv_gap <= $urandom_range(1, 6);
            end else begin
                s_axis_tvalid <= 0;
            end
        end
    end

    // downstream stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1;
            rcv_gap <= 0;
        end else if (rcv_gap > 0) begin
            rcv_gap <= rcv_gap - 1;
            m_axis_tready <= (rcv_gap == 1);
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rcv_gap <= $urandom_range(1, 6);
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.acc = m_axis_tdata[0];
            got.spin = m_axis_tdata[1];
            got.delta = m_axis_tdata[33:2];
            got.energy = m_axis_tdata[81:34];
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp acc=%0d spin=%0d d=%0d e=%0d got acc=%0d spin=%0d d=%0d e=%0d",
                                 want.acc, want.spin, $signed(want.delta), $signed(want.energy),
                                 got.acc, got.spin, $signed(got.delta), $signed(got.energy));
                end
            end
        end
    end

    function automatic t_beat_in rand_beat();
        logic [159:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return t_beat_in'(raw[143:0]);
    endfunction

    // queue a beat and its expectation; every result reports the flip energy
    // of its row, so only loaded rows are reported
    task automatic send(input t_beat_in b);
        if (b.op != OP_LOAD_NODE && b.op != OP_VISIT && !delta_set[b.row]) b.row = '0;
        if (b.op == OP_LOAD_NODE) delta_set[b.row] = 1;
        if (b.op == OP_LOAD_COUPLING) coup_set[b.row][b.col] = 1;
        pending_beats.push_back(b);
        expected_results.push_back(predict_step(b));
    endtask

    task automatic load_node(input int r, input logic s, input logic [31:0] d);
        t_beat_in b;
        b = rand_beat();
        b.op = OP_LOAD_NODE; b.row = 6'(r); b.spin = s; b.delta = d;
        send(b);
    endtask

    task automatic load_coup(input int r, input int c, input logic [15:0] v);
        t_beat_in b;
        b = rand_beat();
        b.op = OP_LOAD_COUPLING; b.row = 6'(r); b.col = 6'(c); b.coup = v;
        send(b);
    endtask

    task automatic visit(input int r, input logic [15:0] beta, input logic [15:0] rnd);
        t_beat_in b;
        b = rand_beat();
        b.op = OP_VISIT; b.row = 6'(r); b.beta = beta; b.rnd = rnd;
        send(b);
    endtask

    task automatic drain();
        while (expected_results.size() > 0 || pending_beats.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic set_nodes(input int n);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= n[6:0];
        @(posedge i_clk);
        i_cfg_we <= 0;
        mdl_nodes = n > 64 ? 64 : n;
    endtask

    // a visit is legal only if its walk and its result touch written entries
    function automatic bit visit_ok(input int r);
        if (!delta_set[r]) return 0;
        if (r >= mdl_nodes) return 1;
        for (int j = 0; j < mdl_nodes; j++)
            if (j != r && (!delta_set[j] || !coup_set[r][j])) return 0;
        return 1;
    endfunction

    initial begin
        int nsel [5];
        int nrows;
        t_beat_in b;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_wdata = 0;
        s_axis_tdata = 0;
        mismatches = 0;
        quiet = 0;
        build_tables();
        for (int i = 0; i < 64; i++) begin
            mdl_spin[i] = 0; mdl_delta[i] = 0; delta_set[i] = 0;
            for (int j = 0; j < 64; j++) begin
                mdl_coup[i][j] = 0; coup_set[i][j] = 0;
            end
        end
        mdl_energy = 0;
        mdl_nodes = 64;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, saturation, all opcodes, out-of-range visit
        set_nodes(4);
        load_node(0, 0, 32'h8000_0000);
        load_node(1, 1, 32'h7fff_fff0);
        load_node(2, 0, 32'h8000_0005);
        load_node(3, 1, 32'd1);
        load_node(40, 1, 32'd7);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                load_coup(i, j, (i == 0) ? 16'h8000 : 16'h7fff);
        b = rand_beat(); b.op = OP_LOAD_ENERGY; b.energy = 48'h8000_0000_0000; send(b);
        visit(0, 16'hffff, 16'hffff);
        visit(1, 16'h0000, 16'h0000);
        visit(3, 16'h0000, 16'hffff);
        visit(3, 16'hffff, 16'h0000);
        visit(2, 16'h0100, 16'h0000);
        b = rand_beat(); b.op = OP_LOAD_ENERGY; b.energy = 48'h7fff_ffff_ffff; send(b);
        visit(1, 16'h0001, 16'h0000);
        visit(40, 16'h0, 16'h0);
        b = rand_beat(); b.op = OP_READ; b.row = 2; send(b);
        b = rand_beat(); b.op = t_opcode'(3'd7); b.row = 1; send(b);
        b = rand_beat(); b.op = t_opcode'(3'd5); b.row = 40; send(b);
        drain();

        set_nodes(0);
        visit(0, 0, 0);
        visit(40, 0, 0);
        drain();

        // random phases over several node counts
        nsel = '{2, 64, 1, 9, 100};
        foreach (nsel[p]) begin
            set_nodes(nsel[p]);
            nrows = mdl_nodes < 4 ? mdl_nodes : 4;
            for (int i = 0; i < mdl_nodes; i++)
                load_node(i, $urandom_range(0, 1),
                          $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 800) - 200);
            for (int i = 0; i < nrows; i++)
                for (int j = 0; j < mdl_nodes; j++)
                    load_coup(i, j, $urandom_range(0, 7) == 0 ? 16'($urandom)
                                                              : 16'($urandom_range(0, 60) - 30));
            for (int k = 0; k < 220; k++) begin
                if (p == 4 && k > 150) quiet = 1;
                b = rand_beat();
                case ($urandom_range(0, 9))
                    0: begin b.op = OP_LOAD_COUPLING; b.row = 6'($urandom_range(0, mdl_nodes - 1));
                              b.col = 6'($urandom_range(0, mdl_nodes - 1)); end
                    1: begin b.op = OP_LOAD_NODE; b.row = 6'($urandom_range(0, mdl_nodes - 1));
                              if ($urandom_range(0, 1)) b.delta = $urandom_range(0, 3000) - 500;
                       end
                    2: b.op = OP_LOAD_ENERGY;
                    3: b.op = t_opcode'(3'($urandom_range(4, 7)));
                    default: begin
                        b.op = OP_VISIT;
                        b.row = $urandom_range(0, 3) == 0 ? 6'($urandom)
                                                          : 6'($urandom_range(0, nrows - 1));
                        if ($urandom_range(0, 1)) b.beta = 16'($urandom_range(0, 1024));
                    end
                endcase
                if (b.op == OP_VISIT && !visit_ok(b.row)) b.op = OP_READ;
                if (b.op == OP_READ && !delta_set[b.row]) b.row = 0;
                if (b.op != OP_LOAD_NODE && b.op != OP_LOAD_COUPLING && b.op != OP_LOAD_ENERGY
                    && b.op != OP_VISIT && !delta_set[b.row]) b.op = OP_LOAD_ENERGY;
                send(b);
            end
            drain();
        end

        if (mismatches == 0)
            $display("qubo_metropolis_node_update_tb: clean");
        else
            $display("qubo_metropolis_node_update_tb: errors");
        $finish;
    end

    initial begin
        #4000000;
        $display("qubo_metropolis_node_update_tb: errors");
        $finish;
    end
endmodule
